// ===== rtl/rlcd_pkg.sv =====
// Shared types, constants and helper functions of the run-length cell array decoder.
package rlcd_pkg;

   localparam int unsigned AccWidth    = 56;
   localparam int unsigned PairWidth   = 46;
   localparam int unsigned ColourWidth = 30;
   localparam int unsigned RecipShift  = 30;

   localparam logic [2:0] CSR_CELLS_PER_ROW  = 3'd0;
   localparam logic [2:0] CSR_ROW_COUNT      = 3'd1;
   localparam logic [2:0] CSR_COLOR_MODE     = 3'd2;
   localparam logic [2:0] CSR_INDEX_BITS     = 3'd3;
   localparam logic [2:0] CSR_COMPONENT_BITS = 3'd4;

   typedef struct packed {
      logic [15:0] cells_per_row;
      logic [15:0] row_count;
      logic        color_mode;
      logic [4:0]  index_bits;
      logic [3:0]  component_bits;
   } cfg_type;

   typedef struct packed {
      logic [15:0]            row;
      logic [15:0]            start;
      logic [15:0]            len;
      logic [ColourWidth-1:0] colour;
      logic                   row_done;
      logic                   array_done;
      logic                   last;
   } run_type;

   function automatic logic [3:0] comp_width(input logic [3:0] cb);
      logic [3:0] c;
      c = cb;
      if (c == 4'd0) c = 4'd8;
      if (c > 4'd10) c = 4'd10;
      return c;
   endfunction

   function automatic logic [5:0] colour_width(input cfg_type cfg);
      logic [4:0] ib;
      ib = cfg.index_bits;
      if (ib == 5'd0) ib = 5'd8;
      if (ib > 5'd24) ib = 5'd24;
      if (cfg.color_mode) return 6'(comp_width(cfg.component_bits)) * 6'd3;
      return {1'b0, ib};
   endfunction

   // Rounded-up reciprocal of (2^c - 1), scaled by 2^30; exact for every rounded sum used.
   function automatic logic [30:0] recip(input logic [3:0] c);
      logic [30:0] r;
      case (c)
         4'd1:    r = 31'd1073741824;
         4'd2:    r = 31'd357913942;
         4'd3:    r = 31'd153391690;
         4'd4:    r = 31'd71582789;
         4'd5:    r = 31'd34636834;
         4'd6:    r = 31'd17043522;
         4'd7:    r = 31'd8454661;
         4'd8:    r = 31'd4210753;
         4'd9:    r = 31'd2101257;
         4'd10:   r = 31'd1049602;
         default: r = 31'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/rlcd_queue.sv =====
// Two-entry queue of decoded runs between the bit assembler and the colour scaler.
module rlcd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rlcd_pkg::run_type push_data,
   output logic             full,
   input  logic             pop,
   output rlcd_pkg::run_type pop_data,
   output logic             empty
);

   rlcd_pkg::run_type mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff ^ push;
      rd_in    = rd_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue fill count out of range");
`endif

endmodule

// ===== rtl/rlcd_front.sv =====
// Bit assembler: takes bytes, cuts count/colour pairs and keeps row bookkeeping.
module rlcd_front (
   input  logic              clock,
   input  logic              reset,
   input  rlcd_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_final_byte,
   input  logic              q_full,
   output logic              q_push,
   output rlcd_pkg::run_type  q_data
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_PAIR  = 4'b0010,
      S_PAD   = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [rlcd_pkg::AccWidth-1:0] acc_ff, acc_in;
   logic [5:0]  held_ff, held_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] filled_ff, filled_in;
   logic        parity_ff, parity_in;
   logic        skip_ff, skip_in;
   logic        fin_ff, fin_in;
   logic [1:0]  results_ff, results_in;
   logic        last_ff, last_in;
   logic        hold_valid_ff, hold_valid_in;
   rlcd_pkg::run_type hold_ff, hold_in;

   logic [5:0]  n, p, pair_sh;
   logic        active_ok, accept, decode_go;
   logic [rlcd_pkg::PairWidth-1:0]   pmask, pair_x, pair_pad, pair;
   logic [rlcd_pkg::AccWidth-1:0]    pad_sh;
   logic [rlcd_pkg::ColourWidth-1:0] cmask, colour;
   logic [15:0] count, upper, len, row_next;
   logic [16:0] upper_raw;
   logic        dec_end, rdone, adone, end_fin, row_end;
   rlcd_pkg::run_type new_run;

   assign n         = rlcd_pkg::colour_width(cfg);
   assign p         = 6'd16 + n;
   assign active_ok = !fin_ff && cfg.cells_per_row != 16'd0 && cfg.row_count != 16'd0
                      && row_ff < cfg.row_count;
   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;

   // Pair source: the top p held bits, or the short tail padded with zeros.
   assign pmask    = (rlcd_pkg::PairWidth'(1) << p) - rlcd_pkg::PairWidth'(1);
   assign pair_sh  = held_ff - p;
   assign pair_x   = rlcd_pkg::PairWidth'(acc_ff >> pair_sh) & pmask;
   assign pad_sh   = acc_ff << (p - held_ff);
   assign pair_pad = pad_sh[rlcd_pkg::PairWidth-1:0] & pmask;
   assign pair     = (state_ff == S_PAD) ? pair_pad : pair_x;

   assign cmask     = (rlcd_pkg::ColourWidth'(1) << n) - rlcd_pkg::ColourWidth'(1);
   assign count     = 16'(pair >> n);
   assign colour    = rlcd_pkg::ColourWidth'(pair) & cmask;
   assign dec_end   = count == 16'd0 || filled_ff >= cfg.cells_per_row;
   assign upper_raw = {1'b0, filled_ff} + {1'b0, count};
   assign upper     = (upper_raw > {1'b0, cfg.cells_per_row}) ? cfg.cells_per_row
                                                               : upper_raw[15:0];
   assign len       = upper - filled_ff;
   assign rdone     = upper >= cfg.cells_per_row;
   assign adone     = rdone && ({1'b0, row_ff} + 17'd1 >= {1'b0, cfg.row_count});
   assign row_next  = row_ff + 16'd1;
   assign end_fin   = row_next >= cfg.row_count || row_next == 16'd0;
   assign row_end   = dec_end || rdone;

   always_comb begin
      new_run            = '0;
      new_run.row        = row_ff;
      new_run.start      = filled_ff;
      new_run.len        = len;
      new_run.colour     = colour;
      new_run.row_done   = rdone;
      new_run.array_done = adone;
   end

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      held_in       = held_ff;
      row_in        = row_ff;
      filled_in     = filled_ff;
      parity_in     = parity_ff;
      skip_in       = skip_ff;
      fin_in        = fin_ff;
      results_in    = results_ff;
      last_in       = last_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      q_push        = 1'b0;
      q_data        = hold_ff;
      decode_go     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!active_ok) begin
                  if (req_final_byte) fin_in = 1'b1;
               end else if (skip_ff) begin
                  skip_in = 1'b0;
                  if (req_final_byte) fin_in = 1'b1;
               end else begin
                  acc_in     = {acc_ff[rlcd_pkg::AccWidth-9:0], req_data_byte};
                  held_in    = held_ff + 6'd8;
                  parity_in  = !parity_ff;
                  results_in = 2'd0;
                  last_in    = req_final_byte;
                  state_in   = S_PAIR;
               end
            end
         end
         S_PAIR: begin
            if (!q_full) begin
               if (results_ff < 2'd2 && !fin_ff && held_ff >= p) begin
                  decode_go = 1'b1;
                  held_in   = pair_sh;
                  state_in  = row_end ? S_PAD : S_PAIR;
               end else begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            if (!q_full) begin
               if (last_ff) begin
                  if (results_ff < 2'd2 && !fin_ff && held_ff != 6'd0 && held_ff < p) begin
                     decode_go = 1'b1;
                     acc_in    = '0;
                     held_in   = 6'd0;
                  end
                  fin_in = 1'b1;
               end
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!q_full) begin
               if (hold_valid_ff) begin
                  q_push        = 1'b1;
                  q_data.last   = 1'b1;
                  hold_valid_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Each run waits for the next run or the flush so the last of a byte can be marked.
      if (decode_go) begin
         if (row_end) begin
            acc_in    = '0;
            held_in   = 6'd0;
            skip_in   = parity_ff;
            parity_in = 1'b0;
            filled_in = 16'd0;
            row_in    = row_next;
            if (end_fin) fin_in = 1'b1;
         end
         if (!dec_end) begin
            if (!rdone) filled_in = upper;
            results_in    = results_ff + 2'd1;
            hold_in       = new_run;
            hold_valid_in = 1'b1;
            if (hold_valid_ff) q_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         acc_ff        <= '0;
         held_ff       <= 6'd0;
         row_ff        <= 16'd0;
         filled_ff     <= 16'd0;
         parity_ff     <= 1'b0;
         skip_ff       <= 1'b0;
         fin_ff        <= 1'b0;
         results_ff    <= 2'd0;
         last_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         held_ff       <= held_in;
         row_ff        <= row_in;
         filled_ff     <= filled_in;
         parity_ff     <= parity_in;
         skip_ff       <= skip_in;
         fin_ff        <= fin_in;
         results_ff    <= results_in;
         last_ff       <= last_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) q_push |-> state_ff != S_IDLE)
      else $error("run pushed while waiting for a request");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && !q_full) |=> !hold_valid_ff)
      else $error("held run survived the end of its request");
   assert property (@(posedge clock) disable iff (reset) results_ff != 2'd3)
      else $error("more than two runs from one request");
`endif

endmodule

// ===== rtl/rlcd_back.sv =====
// Colour scaler: rounds each direct-mode component to 8 bits and registers the result.
module rlcd_back (
   input  logic              clock,
   input  logic              reset,
   input  rlcd_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  rlcd_pkg::run_type  q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_row_index,
   output logic [15:0]       rsp_start_column,
   output logic [15:0]       rsp_run_length,
   output logic [23:0]       rsp_color_index,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic              rsp_row_done,
   output logic              rsp_array_done,
   output logic              rsp_last_of_item
);

   logic        advance;
   logic [3:0]  cw;
   logic [9:0]  cmask;
   logic [2:0][9:0]  raw;
   logic [2:0][17:0] x_in;
   logic [2:0][48:0] prod;
   logic [2:0][7:0]  comp_in;

   logic              s1_valid_ff, s2_valid_ff, out_valid_ff;
   rlcd_pkg::run_type s1_run_ff, s2_run_ff, out_run_ff;
   logic [2:0][17:0]  s1_x_ff;
   logic [3:0]        s1_c_ff;
   logic [2:0][18:0]  s2_q_ff;
   logic [2:0][7:0]   out_comp_ff;

   assign advance = !out_valid_ff || !rsp_stall;
   assign q_pop   = advance && !q_empty;
   assign cw      = rlcd_pkg::comp_width(cfg.component_bits);
   assign cmask   = (10'd1 << cw) - 10'd1;

   // Components are packed red, green, blue from the top.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         raw[i]  = 10'(q_data.colour >> (6'(cw) * 6'(2 - i))) & cmask;
         x_in[i] = 18'(raw[i]) * 18'd255 + 18'(cmask >> 1);
         prod[i] = 49'(s1_x_ff[i]) * 49'(rlcd_pkg::recip(s1_c_ff));
         comp_in[i] = (s2_q_ff[i] > 19'd255) ? 8'd255 : s2_q_ff[i][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !q_empty;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_run_ff   <= q_data;
         s1_x_ff     <= x_in;
         s1_c_ff     <= cw;
         s2_run_ff   <= s1_run_ff;
         for (int i = 0; i < 3; i++) begin
            s2_q_ff[i] <= prod[i][48:rlcd_pkg::RecipShift];
         end
         out_run_ff  <= s2_run_ff;
         out_comp_ff <= comp_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_row_index    = out_run_ff.row;
   assign rsp_start_column = out_run_ff.start;
   assign rsp_run_length   = out_run_ff.len;
   assign rsp_color_index  = cfg.color_mode ? 24'd0 : out_run_ff.colour[23:0];
   assign rsp_red          = cfg.color_mode ? out_comp_ff[0] : 8'd0;
   assign rsp_green        = cfg.color_mode ? out_comp_ff[1] : 8'd0;
   assign rsp_blue         = cfg.color_mode ? out_comp_ff[2] : 8'd0;
   assign rsp_row_done     = out_run_ff.row_done;
   assign rsp_array_done   = out_run_ff.array_done;
   assign rsp_last_of_item = out_run_ff.last;

endmodule

// ===== rtl/cell_array_run_length_decoder.sv =====
// Top level: configuration registers, bit assembler, run queue and colour scaler.
// A data request holds the assembler through the pair, pad and flush states, and longer while the
// queue is full; padding and ignored requests are taken without leaving the idle state. A run
// enters the queue when the next run of its request is decoded or in the flush state, and passes
// the scaler registers s1, s2 and out on its way to the result port.
// Synchronous reset clears all control state and loads the register defaults; no clearing pass.
module cell_array_run_length_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_row_index,
   output logic [15:0] rsp_start_column,
   output logic [15:0] rsp_run_length,
   output logic [23:0] rsp_color_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_row_done,
   output logic        rsp_array_done,
   output logic        rsp_last_of_item
);

   rlcd_pkg::cfg_type cfg_ff, cfg_in;
   rlcd_pkg::run_type push_data, pop_data;
   logic q_push, q_full, q_pop, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rlcd_pkg::CSR_CELLS_PER_ROW:  cfg_in.cells_per_row  = csr_write_data;
            rlcd_pkg::CSR_ROW_COUNT:      cfg_in.row_count      = csr_write_data;
            rlcd_pkg::CSR_COLOR_MODE:     cfg_in.color_mode     = csr_write_data[0];
            rlcd_pkg::CSR_INDEX_BITS:     cfg_in.index_bits     = csr_write_data[4:0];
            rlcd_pkg::CSR_COMPONENT_BITS: cfg_in.component_bits = csr_write_data[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_per_row  <= 16'd0;
         cfg_ff.row_count      <= 16'd0;
         cfg_ff.color_mode     <= 1'b0;
         cfg_ff.index_bits     <= 5'd8;
         cfg_ff.component_bits <= 4'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlcd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (push_data)
   );

   rlcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   rlcd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_data           (pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_index    (rsp_row_index),
      .rsp_start_column (rsp_start_column),
      .rsp_run_length   (rsp_run_length),
      .rsp_color_index  (rsp_color_index),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_row_done     (rsp_row_done),
      .rsp_array_done   (rsp_array_done),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

// ===== tb/cell_array_run_length_decoder_tb.sv =====
// Self-checking testbench for the run-length cell array decoder.
`timescale 1ns / 100ps

module cell_array_run_length_decoder_tb;

   typedef struct packed {
      logic [15:0] row;
      logic [15:0] col;
      logic [15:0] len;
      logic [23:0] cidx;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        row_done;
      logic        array_done;
      logic        last;
   } exp_run_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        typed;
      logic        has_run;
      exp_run_type run;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = rlcd_pkg::CSR_CELLS_PER_ROW;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_row_index;
   logic [15:0] rsp_start_column;
   logic [15:0] rsp_run_length;
   logic [23:0] rsp_color_index;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_row_done;
   logic        rsp_array_done;
   logic        rsp_last_of_item;

   cell_array_run_length_decoder dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Decoder state as the predictor sees it.
   logic [15:0] cpr_reg, rows_reg;
   logic        mode_reg;
   logic [4:0]  ib_reg;
   logic [3:0]  cb_reg;
   logic [63:0] acc;
   int unsigned held;
   logic [15:0] cur_row, filled;
   bit          parity, skip_pad, halted;

   exp_run_type runs_due[$];
   int   errors = 0;
   bit   quiet = 1'b0;
   bit   press_go = 1'b0;
   bit   press_done = 1'b0;
   int   press_left = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;
   int   phase_bytes;

   function automatic int unsigned comp_bits();
      int unsigned c;
      c = 32'(cb_reg);
      if (c == 0) c = 8;
      if (c > 10) c = 10;
      return c;
   endfunction

   function automatic int unsigned colour_bits();
      int unsigned n;
      if (mode_reg) return 3 * comp_bits();
      n = 32'(ib_reg);
      if (n == 0) n = 8;
      if (n > 24) n = 24;
      return n;
   endfunction

   function automatic logic [7:0] scale_to_byte(longint unsigned raw, int unsigned c);
      longint unsigned mask, v;
      mask = (64'd1 << c) - 1;
      raw &= mask;
      if (mask == 255) return raw[7:0];
      v = (raw * 255 + mask / 2) / mask;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   task automatic close_row();
      acc = '0;
      held = 0;
      skip_pad = parity;
      parity = 1'b0;
      filled = '0;
      cur_row = cur_row + 16'd1;
      if (cur_row >= rows_reg || cur_row == 16'd0) halted = 1'b1;
   endtask

   task automatic decode_pair(input logic [63:0] pair, input int unsigned n,
                              output bit got, output exp_run_type o);
      int unsigned count, upper, c;
      longint unsigned colour;
      count = 32'((pair >> n) & 64'hFFFF);
      colour = pair & ((64'd1 << n) - 1);
      got = 1'b0;
      o = '0;
      if (count == 0 || filled >= cpr_reg) begin
         close_row();
         return;
      end
      upper = 32'(filled) + count;
      if (upper > 32'(cpr_reg)) upper = 32'(cpr_reg);
      o.row = cur_row;
      o.col = filled;
      o.len = 16'(upper - 32'(filled));
      if (mode_reg) begin
         c = comp_bits();
         o.red = scale_to_byte(colour >> (2 * c), c);
         o.green = scale_to_byte(colour >> c, c);
         o.blue = scale_to_byte(colour, c);
      end else begin
         o.cidx = colour[23:0];
      end
      o.row_done = (upper >= 32'(cpr_reg));
      o.array_done = o.row_done && (int'(cur_row) + 1 >= int'(rows_reg));
      if (o.row_done) close_row();
      else filled = 16'(upper);
      got = 1'b1;
   endtask

   // Steps the predictor by one accepted byte; queues the runs it yields if asked.
   task automatic decode_byte(input logic [7:0] b, input bit fin, input bit keep);
      exp_run_type res[2];
      exp_run_type o;
      int nres;
      int unsigned n, p, sh;
      logic [63:0] pair;
      logic [15:0] start_row;
      bit got;
      nres = 0;
      if (halted || cpr_reg == 0 || rows_reg == 0 || cur_row >= rows_reg) begin
         if (fin) halted = 1'b1;
         return;
      end
      if (skip_pad) begin
         skip_pad = 1'b0;
         if (fin) halted = 1'b1;
         return;
      end
      n = colour_bits();
      p = 16 + n;
      acc = (acc << 8) | 64'(b);
      held += 8;
      parity = ~parity;
      while (nres < 2 && !halted && held >= p) begin
         sh = held - p;
         pair = (acc >> sh) & ((64'd1 << p) - 1);
         held = sh;
         acc &= (64'd1 << sh) - 1;
         start_row = cur_row;
         decode_pair(pair, n, got, o);
         if (got) begin
            res[nres] = o;
            nres++;
         end
         if (cur_row != start_row) break;
      end
      if (fin) begin
         // A partly received pair is completed with zero bits.
         if (nres < 2 && !halted && held > 0 && held < p) begin
            pair = (acc << (p - held)) & ((64'd1 << p) - 1);
            acc = '0;
            held = 0;
            decode_pair(pair, n, got, o);
            if (got) begin
               res[nres] = o;
               nres++;
            end
         end
         halted = 1'b1;
      end
      if (nres > 0) res[nres - 1].last = 1'b1;
      if (keep) for (int i = 0; i < nres; i++) runs_due.insert(runs_due.size(), res[i]);
   endtask

   task automatic send(input logic [7:0] b, input bit fin, input bit keep);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_final_byte <= fin;
      do @(posedge clock); while (req_stall);
      decode_byte(b, fin, keep);
      phase_bytes++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (runs_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         rlcd_pkg::CSR_CELLS_PER_ROW:  cpr_reg = value;
         rlcd_pkg::CSR_ROW_COUNT:      rows_reg = value;
         rlcd_pkg::CSR_COLOR_MODE:     mode_reg = value[0];
         rlcd_pkg::CSR_INDEX_BITS:     ib_reg = value[4:0];
         rlcd_pkg::CSR_COMPONENT_BITS: cb_reg = value[3:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [15:0] cpr, input logic [15:0] rows, input logic mode,
                           input logic [4:0] ib, input logic [3:0] cb);
      write_csr(rlcd_pkg::CSR_CELLS_PER_ROW, cpr);
      write_csr(rlcd_pkg::CSR_ROW_COUNT, rows);
      write_csr(rlcd_pkg::CSR_COLOR_MODE, {15'd0, mode});
      write_csr(rlcd_pkg::CSR_INDEX_BITS, {11'd0, ib});
      write_csr(rlcd_pkg::CSR_COMPONENT_BITS, {12'd0, cb});
      csr_write_enable <= 1'b0;
   endtask

   // One well-formed row: up to six pairs, until the row is full or a zero count, then byte and
   // even-length padding with random filler.
   task automatic send_row();
      bit bits[$];
      logic [7:0] b;
      logic [15:0] cnt;
      logic [29:0] colour;
      int unsigned n, total, nbytes;
      n = colour_bits();
      total = 0;
      for (int k = 0; k < 6; k++) begin
         case ($urandom_range(0, 19))
            0:       cnt = 16'd0;
            1:       cnt = 16'hFFFF;
            default: cnt = 16'($urandom_range(1, (cpr_reg > 40) ? 4000 : cpr_reg));
         endcase
         colour = 30'($urandom);
         for (int i = 15; i >= 0; i--) bits.insert(bits.size(), cnt[i]);
         for (int i = int'(n) - 1; i >= 0; i--) bits.insert(bits.size(), colour[i]);
         total += 32'(cnt);
         if (cnt == 0 || total >= cpr_reg) break;
      end
      while (bits.size() % 8 != 0) bits.insert(bits.size(), 1'($urandom_range(0, 1)));
      nbytes = bits.size() / 8;
      for (int i = 0; i < nbytes; i++) begin
         for (int j = 0; j < 8; j++) b[7 - j] = bits[8 * i + j];
         send(b, 1'b0, 1'b1);
      end
      if (nbytes % 2 == 1) send(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic check_run();
      exp_run_type want;
      if (runs_due.size() == 0) begin
         $error("unexpected run: row %0d column %0d", rsp_row_index, rsp_start_column);
         errors++;
         return;
      end
      want = runs_due.pop_front();
      if (rsp_row_index !== want.row) begin
         $error("row_index: expected %0d, got %0d", want.row, rsp_row_index); errors++;
      end
      if (rsp_start_column !== want.col) begin
         $error("start_column: expected %0d, got %0d", want.col, rsp_start_column); errors++;
      end
      if (rsp_run_length !== want.len) begin
         $error("run_length: expected %0d, got %0d", want.len, rsp_run_length); errors++;
      end
      if (rsp_color_index !== want.cidx) begin
         $error("color_index: expected %0h, got %0h", want.cidx, rsp_color_index); errors++;
      end
      if (rsp_red !== want.red) begin
         $error("red: expected %0d, got %0d", want.red, rsp_red); errors++;
      end
      if (rsp_green !== want.green) begin
         $error("green: expected %0d, got %0d", want.green, rsp_green); errors++;
      end
      if (rsp_blue !== want.blue) begin
         $error("blue: expected %0d, got %0d", want.blue, rsp_blue); errors++;
      end
      if (rsp_row_done !== want.row_done) begin
         $error("row_done: expected %0b, got %0b", want.row_done, rsp_row_done); errors++;
      end
      if (rsp_array_done !== want.array_done) begin
         $error("array_done: expected %0b, got %0b", want.array_done, rsp_array_done);
         errors++;
      end
      if (rsp_last_of_item !== want.last) begin
         $error("last_of_item: expected %0b, got %0b", want.last, rsp_last_of_item); errors++;
      end
   endtask

   // Result side: checking, random stall bursts and one long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_run();
      if (press_left != 0) begin
         press_left <= press_left - 1;
         rsp_stall <= (press_left > 1);
      end else if (press_go && !press_done) begin
         press_done <= 1'b1;
         press_left <= 400;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == 3000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   plan_row_type plan[16];

   initial begin
      cpr_reg = '0; rows_reg = '0; mode_reg = 1'b0; ib_reg = 5'd8; cb_reg = 4'd8;
      acc = '0; held = 0; cur_row = '0; filled = '0;
      parity = 1'b0; skip_pad = 1'b0; halted = 1'b0;
      phase_bytes = 0;

      // Rows of ten cells, 8-bit indices: 24-bit pairs, three bytes each.
      plan[0]  = '{8'h00, 1, 0, '0};
      plan[1]  = '{8'h03, 1, 0, '0};
      plan[2]  = '{8'h7E, 1, 1,
                   exp_run_type'{16'd0, 16'd0, 16'd3, 24'h7E, 8'd0, 8'd0, 8'd0, 0, 0, 1}};
      plan[3]  = '{8'h00, 1, 0, '0};
      plan[4]  = '{8'hFF, 1, 0, '0};
      plan[5]  = '{8'h01, 1, 1,
                   exp_run_type'{16'd0, 16'd3, 16'd7, 24'h01, 8'd0, 8'd0, 8'd0, 1, 0, 1}};
      // A zero count ends row 1 after three bytes, so one padding byte follows.
      plan[6]  = '{8'h00, 1, 0, '0};
      plan[7]  = '{8'h00, 1, 0, '0};
      plan[8]  = '{8'h55, 1, 0, '0};
      plan[9]  = '{8'hAA, 1, 0, '0};
      plan[10] = '{8'hFF, 1, 0, '0};
      plan[11] = '{8'hFF, 1, 0, '0};
      plan[12] = '{8'hFF, 1, 1,
                   exp_run_type'{16'd2, 16'd0, 16'd10, 24'hFF, 8'd0, 8'd0, 8'd0, 1, 0, 1}};
      plan[13] = '{8'h12, 1, 0, '0};
      plan[14] = '{8'h34, 0, 0, '0};
      plan[15] = '{8'h56, 0, 0, '0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With no cells per row every byte is ignored.
      send(8'hFF, 1'b0, 1'b1);
      send(8'h00, 1'b0, 1'b1);
      settle();
      set_regs(16'd10, 16'hFFFF, 1'b0, 5'd8, 4'd8);
      foreach (plan[i]) begin
         send(plan[i].data, 1'b0, !plan[i].typed);
         if (plan[i].typed && plan[i].has_run) runs_due.insert(runs_due.size(), plan[i].run);
      end

      for (int phase = 0; phase < 12; phase++) begin
         logic [15:0] cpr;
         settle();
         quiet = (phase >= 10);
         case ($urandom_range(0, 5))
            0:       cpr = 16'd1;
            1:       cpr = 16'hFFFF;
            default: cpr = 16'($urandom_range(2, 40));
         endcase
         if (phase == 2) cpr = 16'd0;
         set_regs(cpr, (phase == 4) ? 16'd0 : 16'hFFFF, 1'($urandom_range(0, 1)),
                  (phase == 1) ? 5'd31 : 5'($urandom_range(0, 31)),
                  (phase == 3) ? 4'd15 : 4'($urandom_range(0, 15)));
         if (phase == 3) press_go = 1'b1;
         phase_bytes = 0;
         if (phase == 2 || phase == 4) begin
            repeat (20) send(8'($urandom), 1'b0, 1'b1);
         end else begin
            while (phase_bytes < 160) begin
               if ($urandom_range(0, 9) == 0)
                  repeat ($urandom_range(1, 6)) send(8'($urandom), 1'b0, 1'b1);
               else
                  send_row();
            end
         end
      end

      // Bring the stream to a row boundary, then close the array on a padded final pair.
      while (held != 0 || filled != 0 || skip_pad) send(8'h00, 1'b0, 1'b1);
      settle();
      set_regs(16'd8181, cur_row + 16'd1, 1'b0, 5'd4, 4'd0);
      send(8'h00, 1'b0, 1'b1);
      send(8'h05, 1'b0, 1'b1);
      send(8'h71, 1'b0, 1'b1);
      send(8'hFF, 1'b1, 1'b1);
      send(8'h3C, 1'b0, 1'b1);
      send(8'hC3, 1'b0, 1'b1);
      req_valid <= 1'b0;

      while (runs_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
